>>> sv/mbe_pkg.sv
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types, widths and constants of the escape-time block.
// ----------------------------------------------------------------------------
package mbe_pkg;

    localparam int FRACTION_BITS     = 28;
    localparam int MAX_DIMENSION_DEF = 4096;

    localparam int COORD_W = FRACTION_BITS + 4;   // signed Q4.F
    localparam int PROD_W  = 2 * COORD_W;

    localparam int POS_W      = 12;
    localparam int DIM_W      = 13;
    localparam int COUNT_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;

    localparam logic [DIM_W-1:0]   WIDTH_RST  = DIM_W'(800);
    localparam logic [DIM_W-1:0]   HEIGHT_RST = DIM_W'(800);
    localparam logic [COUNT_W-1:0] LIMIT_RST  = COUNT_W'(1000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_LIMIT  = 2'd2
    } t_cfg_index;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_RE,
        ST_DIV_IM,
        ST_MUL,
        ST_ADD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;     // clear z
        logic mul_en;   // register the three products
        logic upd_en;   // write back the new z
    } t_core_ctrl;

    // zero acts as one, anything above the maximum acts as the maximum
    function automatic logic [DIM_W-1:0] f_dim(input logic [DIM_W-1:0] cfg_v,
                                               input int max_dim);
        logic [DIM_W-1:0] res;
        if (cfg_v == '0) begin
            res = DIM_W'(1);
        end else if (int'(cfg_v) > max_dim) begin
            res = DIM_W'(max_dim);
        end else begin
            res = cfg_v;
        end
        return res;
    endfunction

endpackage

>>> sv/mbe_coord_div.sv
// ----------------------------------------------------------------------------
// mbe_coord_div
// Bit-serial restoring divider: coord = floor(4*pos*2^F/dim) - 2*2^F.
// ----------------------------------------------------------------------------
module mbe_coord_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [mbe_pkg::POS_W-1:0]           i_pos,
    input  logic [mbe_pkg::DIM_W-1:0]           i_dim,
    output logic                                o_done,
    output logic signed [mbe_pkg::COORD_W-1:0]  o_coord
);
    import mbe_pkg::*;

    localparam int NUM_W = POS_W + 2 + FRACTION_BITS;
    localparam int QUO_W = FRACTION_BITS + 2;
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam logic [COORD_W-1:0] TWO_FX = COORD_W'(64'd2 << FRACTION_BITS);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [NUM_W-1:0]     r_num;
    logic [DIM_W-1:0]     r_rem;
    logic [DIM_W-1:0]     r_dim;
    logic [QUO_W-1:0]     r_quo;

    logic [POS_W-1:0]     w_pos;
    logic [DIM_W:0]       w_trial;
    logic [DIM_W:0]       w_sub;
    logic                 w_fits;

    always_comb begin
        // pixel beyond the image is held at the last column or row
        if ({1'b0, i_pos} >= i_dim) begin
            w_pos = POS_W'(i_dim - DIM_W'(1));
        end else begin
            w_pos = i_pos;
        end
        w_trial = {r_rem, r_num[NUM_W-1]};
        w_sub   = w_trial - {1'b0, r_dim};
        w_fits  = (w_trial >= {1'b0, r_dim});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= {w_pos, (QUO_W)'(0)};
            r_rem <= '0;
            r_quo <= '0;
            r_dim <= i_dim;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_rem <= w_fits ? w_sub[DIM_W-1:0] : w_trial[DIM_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], w_fits};
        end
    end

    assign o_done  = r_done;
    assign o_coord = $signed({2'b00, r_quo} - TWO_FX);

endmodule

>>> sv/mbe_iter_core.sv
// ----------------------------------------------------------------------------
// mbe_iter_core
// One z = z*z + c step: product stage, then escape test and update stage.
// ----------------------------------------------------------------------------
module mbe_iter_core (
    input  logic                                i_clk,
    input  mbe_pkg::t_core_ctrl                 i_ctrl,
    input  logic signed [mbe_pkg::COORD_W-1:0]  i_c_re,
    input  logic signed [mbe_pkg::COORD_W-1:0]  i_c_im,
    output logic                                o_escape
);
    import mbe_pkg::*;

    localparam logic [PROD_W:0] FOUR_FX = (PROD_W + 1)'(1) << (2 * FRACTION_BITS + 2);

    logic signed [COORD_W-1:0] r_re;
    logic signed [COORD_W-1:0] r_im;
    logic signed [PROD_W-1:0]  r_sr;
    logic signed [PROD_W-1:0]  r_si;
    logic signed [PROD_W-1:0]  r_xy;

    logic        [PROD_W:0]    w_mag;
    logic signed [PROD_W:0]    w_diff;
    logic signed [PROD_W:0]    w_diff_sh;
    logic signed [PROD_W-1:0]  w_xy_sh;
    logic signed [COORD_W-1:0] n_re;
    logic signed [COORD_W-1:0] n_im;

    always_comb begin
        // both squares are nonnegative
        w_mag     = {1'b0, r_sr} + {1'b0, r_si};
        w_diff    = {r_sr[PROD_W-1], r_sr} - {r_si[PROD_W-1], r_si};
        w_diff_sh = w_diff >>> FRACTION_BITS;
        w_xy_sh   = r_xy >>> (FRACTION_BITS - 1);   // 2*re*im
        n_re      = w_diff_sh[COORD_W-1:0] + i_c_re;
        n_im      = w_xy_sh[COORD_W-1:0] + i_c_im;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_re <= '0;
            r_im <= '0;
        end else if (i_ctrl.upd_en) begin
            r_re <= n_re;
            r_im <= n_im;
        end
        if (i_ctrl.mul_en) begin
            r_sr <= r_re * r_re;
            r_si <= r_im * r_im;
            r_xy <= r_re * r_im;
        end
    end

    assign o_escape = (w_mag >= FOUR_FX);

endmodule

>>> sv/mandelbrot_escape_time.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Escape-time count of one pixel of the Mandelbrot set per input item.
// ----------------------------------------------------------------------------
// Input stream: one item per pixel, column and row. Output stream: one item
// per pixel, the iteration count. Config port writes image width, image height
// and the iteration limit; write it only while the block is idle.
// Flow per item: the pixel is mapped to c by a serial divider, real part then
// imaginary part; then z = z*z + c runs on one shared multiply/update unit,
// each iteration a product stage, then an escape test and write-back stage.
// One item is worked on at a time; the slave side is ready only when idle,
// so the next item can be accepted in the cycle after a result is loaded.
// The result sits in an output register, so a new item can be accepted while
// the previous result still waits; a finished result waits inside until that
// register is free.
// Reset (synchronous, active low) returns to idle, drops output valid and
// loads width 800, height 800 and limit 1000.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time #(
    parameter int MAX_DIMENSION = mbe_pkg::MAX_DIMENSION_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave side
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [mbe_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,  // pixel_column, pixel_row
    // master side
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [mbe_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,  // escape_count
    // config
    input  logic                               i_cfg_we,
    input  logic [mbe_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mbe_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import mbe_pkg::*;

    t_state              r_state;
    t_state              n_state;

    logic [DIM_W-1:0]    r_width;
    logic [DIM_W-1:0]    r_height;
    logic [COUNT_W-1:0]  r_limit;

    logic [POS_W-1:0]    r_row;
    logic [COUNT_W-1:0]  r_count;
    logic                r_out_valid;
    logic [COUNT_W-1:0]  r_out_count;
    logic signed [COORD_W-1:0] r_c_re;
    logic signed [COORD_W-1:0] r_c_im;

    logic                w_in_acc;
    logic                w_div_start;
    logic [POS_W-1:0]    w_div_pos;
    logic [DIM_W-1:0]    w_div_dim;
    logic                w_div_done;
    logic signed [COORD_W-1:0] w_coord;
    logic                w_escape;
    logic                w_out_load;
    logic                w_count_clr;
    logic                w_count_inc;
    t_core_ctrl          w_ctrl;

    assign w_in_acc = i_s_axis_tvalid && o_s_axis_tready;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_limit  <= LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WIDTH:  r_width  <= i_cfg_data[DIM_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[DIM_W-1:0];
                CFG_LIMIT:  r_limit  <= i_cfg_data[COUNT_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        if (r_state == ST_IDLE) begin
            w_div_pos = i_s_axis_tdata[POS_W-1:0];
            w_div_dim = f_dim(r_width, MAX_DIMENSION);
        end else begin
            w_div_pos = r_row;
            w_div_dim = f_dim(r_height, MAX_DIMENSION);
        end
    end

    mbe_coord_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_pos   (w_div_pos),
        .i_dim   (w_div_dim),
        .o_done  (w_div_done),
        .o_coord (w_coord)
    );

    mbe_iter_core u_core (
        .i_clk    (i_clk),
        .i_ctrl   (w_ctrl),
        .i_c_re   (r_c_re),
        .i_c_im   (r_c_im),
        .o_escape (w_escape)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        w_count_clr = 1'b0;
        w_count_inc = 1'b0;
        w_ctrl      = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    w_div_start = 1'b1;
                    w_ctrl.load = 1'b1;
                    w_count_clr = 1'b1;
                    n_state     = ST_DIV_RE;
                end
            end
            ST_DIV_RE: begin
                if (w_div_done) begin
                    w_div_start = 1'b1;
                    n_state     = ST_DIV_IM;
                end
            end
            ST_DIV_IM: begin
                if (w_div_done) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                if (r_count == r_limit) begin
                    n_state = ST_DONE;
                end else begin
                    w_ctrl.mul_en = 1'b1;
                    n_state       = ST_ADD;
                end
            end
            ST_ADD: begin
                if (w_escape) begin
                    n_state = ST_DONE;
                end else begin
                    w_ctrl.upd_en = 1'b1;
                    w_count_inc   = 1'b1;
                    n_state       = ST_MUL;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_row <= i_s_axis_tdata[2*POS_W-1:POS_W];
        end
        if (w_div_done && r_state == ST_DIV_RE) begin
            r_c_re <= w_coord;
        end
        if (w_div_done && r_state == ST_DIV_IM) begin
            r_c_im <= w_coord;
        end
        if (w_count_clr) begin
            r_count <= '0;
        end else if (w_count_inc) begin
            r_count <= r_count + COUNT_W'(1);
        end
        if (w_out_load) begin
            r_out_count <= r_count;
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_count;

endmodule

>>> sv/mbe_checker.sv
// ----------------------------------------------------------------------------
// mbe_checker
// Port-level checks of the escape-time block, bound to the top level.
// ----------------------------------------------------------------------------
module mbe_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    input  logic                               o_s_axis_tready,
    input  logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    input  logic [mbe_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata
);
    import mbe_pkg::*;

    // a pending result stays until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    // result data holds while stalled
    a_out_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> $stable(o_m_axis_tdata))
        else $error("result data changed while stalled");

    // accepted item keeps the block busy next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("ready after accepting an item");

    // a new result is raised only while the block is idle
    a_result_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> o_s_axis_tready)
        else $error("result raised while still busy");

    // an accept is not followed too soon by a result
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> ##1 !$rose(o_m_axis_tvalid))
        else $error("result too soon after accept");

endmodule

bind mandelbrot_escape_time mbe_checker u_mbe_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
